### rtl/selective_repeat_sender_defines.svh
// Assertion macros for the checker file of the sender.
`ifndef SELECTIVE_REPEAT_SENDER_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SRS_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/srs_pkg.sv
`default_nettype none

package srs_pkg;

  // Field and register widths
  localparam int FRAME_COUNT_W = 8;
  localparam int WIN_LEN_W     = 5;
  localparam int TIMEOUT_W     = 16;
  localparam int SEQ_W         = 8;
  localparam int KIND_W        = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  // Input operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_LEN       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Register reset values
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 8'd0;
  localparam logic [WIN_LEN_W-1:0]     WIN_LEN_RST     = 5'd4;
  localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RST     = 16'd3;

  typedef struct packed {
    logic             op;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  frame_seq;
    logic              last;
    logic              all_done;
  } out_item_t;

  typedef struct packed {
    logic [FRAME_COUNT_W-1:0] frame_count;
    logic [WIN_LEN_W-1:0]     win_len;
    logic [TIMEOUT_W-1:0]     timeout_ticks;
  } cfg_t;

  // Sequencer to output buffer
  typedef struct packed {
    logic              push;
    logic              close;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  frame_seq;
    logic              all_done;
  } obuf_cmd_t;

  // Output buffer to sequencer
  typedef struct packed {
    logic push_ok;
    logic close_ok;
  } obuf_stat_t;

endpackage

`default_nettype wire

### rtl/srs_mem.sv
`default_nettype none

module srs_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 18
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data
);

  logic [DW-1:0] store_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/srs_obuf.sv
`default_nettype none

module srs_obuf
  import srs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire obuf_cmd_t  cmd,
  output obuf_stat_t      stat,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  logic              pend_v_r, pend_v_nxt;
  logic [KIND_W-1:0] pend_kind_r, pend_kind_nxt;
  logic [SEQ_W-1:0]  pend_seq_r, pend_seq_nxt;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_free;

  assign out_free      = !out_v_r || !out_stall;
  assign stat.push_ok  = !pend_v_r || out_free;
  assign stat.close_ok = out_free;

  // Hold the latest send back until the next one or the end of the item sets last
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_seq_nxt  = pend_seq_r;
    out_v_nxt     = out_v_r && out_stall;
    out_nxt       = out_r;
    if (cmd.push && stat.push_ok) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = '{kind: pend_kind_r, frame_seq: pend_seq_r, last: 1'b0,
                      all_done: cmd.all_done};
      end
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = cmd.kind;
      pend_seq_nxt  = cmd.frame_seq;
    end else if (cmd.close && stat.close_ok) begin
      out_v_nxt  = 1'b1;
      pend_v_nxt = 1'b0;
      if (pend_v_r) begin
        out_nxt = '{kind: pend_kind_r, frame_seq: pend_seq_r, last: 1'b1,
                    all_done: cmd.all_done};
      end else begin
        out_nxt = '{kind: KIND_STATUS, frame_seq: '0, last: 1'b1,
                    all_done: cmd.all_done};
      end
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pend_seq_r  <= pend_seq_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/srs_seq.sv
`default_nettype none

module srs_seq
  import srs_pkg::*;
#(
  parameter int MAX_FRAME_SLOTS = 128,
  parameter int MAX_WINDOW      = 16,
  parameter int STAMP_BITS      = 16,
  parameter int IDX_W           = 7,
  parameter int DW              = 18
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output logic [DW-1:0]         mem_wdata,
  output logic                  mem_re,
  output logic [IDX_W-1:0]      mem_raddr,
  input  wire logic [DW-1:0]    mem_rdata,
  output obuf_cmd_t             cmd,
  input  wire obuf_stat_t       stat
);

  localparam int CNT_W  = $clog2(MAX_FRAME_SLOTS + 1);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int CC_W   = (CNT_W > FRAME_COUNT_W) ? CNT_W : FRAME_COUNT_W;
  localparam int WC_W   = (WIN_W > WIN_LEN_W) ? WIN_W : WIN_LEN_W;
  localparam int TO_W   = (STAMP_BITS > TIMEOUT_W) ? STAMP_BITS : TIMEOUT_W;
  localparam int SUM_W  = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_FRAME_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACK_CHK,
    S_SLIDE_RD,
    S_SLIDE,
    S_CLOSE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        end_r, end_nxt;
  logic [CNT_W-1:0]        base_r, base_nxt;
  logic [STAMP_BITS-1:0]   tick_r, tick_nxt;
  logic [IDX_W-1:0]        clr_r, clr_nxt;
  logic [IDX_W-1:0]        ack_idx_r, ack_idx_nxt;

  logic [CNT_W-1:0]        eff_count;
  logic [WIN_W-1:0]        eff_win;
  logic [SUM_W-1:0]        win_sum;
  logic [CNT_W-1:0]        end_calc;
  logic                    in_accept;
  logic                    ack_in_range;
  logic                    e_acked;
  logic                    e_sent;
  logic [STAMP_BITS-1:0]   e_stamp;
  logic [STAMP_BITS-1:0]   age;
  logic                    retx_due;
  logic                    send_due;
  logic [CNT_W-1:0]        idx_inc;
  logic [CNT_W-1:0]        base_inc;
  logic [CNT_W:0]          seq_full;

  // Saturate the configured count and window
  always_comb begin
    if (CC_W'(cfg.frame_count) > CC_W'(MAX_FRAME_SLOTS)) begin
      eff_count = CNT_W'(MAX_FRAME_SLOTS);
    end else begin
      eff_count = CNT_W'(cfg.frame_count);
    end
    if (WC_W'(cfg.win_len) > WC_W'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = WIN_W'(cfg.win_len);
    end
  end

  // Scan limit: window end or frame count, whichever is lower
  assign win_sum  = SUM_W'(base_r) + SUM_W'(eff_win);
  assign end_calc = (win_sum < SUM_W'(eff_count)) ? CNT_W'(win_sum) : eff_count;

  assign in_stall     = (state_r != S_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign ack_in_range = (in_data.ack_seq != '0) &&
                        (CC_W'(in_data.ack_seq) <= CC_W'(eff_count));

  // Unpack the entry from the last memory read
  assign e_acked  = mem_rdata[DW-1];
  assign e_sent   = mem_rdata[DW-2];
  assign e_stamp  = mem_rdata[STAMP_BITS-1:0];
  assign age      = tick_r - e_stamp;
  assign retx_due = TO_W'(age) >= TO_W'(cfg.timeout_ticks);
  assign send_due = !e_acked && (!e_sent || retx_due);

  assign idx_inc  = idx_r + CNT_W'(1);
  assign base_inc = base_r + CNT_W'(1);
  assign seq_full = {1'b0, idx_r} + (CNT_W + 1)'(1);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    end_nxt      = end_r;
    base_nxt     = base_r;
    tick_nxt     = tick_r;
    clr_nxt      = clr_r;
    ack_idx_nxt  = ack_idx_r;
    mem_we       = 1'b0;
    mem_waddr    = clr_r;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = base_r[IDX_W-1:0];
    cmd.push     = 1'b0;
    cmd.close    = 1'b0;
    cmd.kind     = e_sent ? KIND_RETX : KIND_NEW;
    cmd.frame_seq = SEQ_W'(seq_full);
    cmd.all_done = (base_r >= eff_count);

    case (state_r)
      // Zero every entry after reset
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IDX_W'(1);
        end
      end

      // Take an item and, where it needs one, start its first memory read
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.op == OP_TICK) begin
            tick_nxt = tick_r + STAMP_BITS'(1);
            if (base_r < end_calc) begin
              mem_re    = 1'b1;
              mem_raddr = base_r[IDX_W-1:0];
              idx_nxt   = base_r;
              end_nxt   = end_calc;
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_CLOSE;
            end
          end else if (ack_in_range) begin
            mem_re      = 1'b1;
            mem_raddr   = IDX_W'(in_data.ack_seq - SEQ_W'(1));
            ack_idx_nxt = IDX_W'(in_data.ack_seq - SEQ_W'(1));
            state_nxt   = S_ACK_CHK;
          end else begin
            state_nxt = S_SLIDE_RD;
          end
        end
      end

      // Bar a stall, one slot per cycle: send or resend, restamp, read next
      S_SCAN: begin
        cmd.push = send_due;
        if (!send_due || stat.push_ok) begin
          if (send_due) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r[IDX_W-1:0];
            mem_wdata = {1'b0, 1'b1, tick_r};
          end
          if (idx_inc < end_r) begin
            mem_re    = 1'b1;
            mem_raddr = idx_inc[IDX_W-1:0];
            idx_nxt   = idx_inc;
          end else begin
            state_nxt = S_CLOSE;
          end
        end
      end

      // Mark the acknowledged frame, keep its sent bit and stamp
      S_ACK_CHK: begin
        if (!e_acked) begin
          mem_we    = 1'b1;
          mem_waddr = ack_idx_r;
          mem_wdata = {1'b1, mem_rdata[DW-2:0]};
        end
        state_nxt = S_SLIDE_RD;
      end

      S_SLIDE_RD: begin
        if (base_r < eff_count) begin
          mem_re    = 1'b1;
          mem_raddr = base_r[IDX_W-1:0];
          state_nxt = S_SLIDE;
        end else begin
          state_nxt = S_CLOSE;
        end
      end

      // Advance base past acked frames
      S_SLIDE: begin
        if (e_acked) begin
          base_nxt = base_inc;
          if (base_inc < eff_count) begin
            mem_re    = 1'b1;
            mem_raddr = base_inc[IDX_W-1:0];
          end else begin
            state_nxt = S_CLOSE;
          end
        end else begin
          state_nxt = S_CLOSE;
        end
      end

      // Finish the item: flush the held send or emit a status result
      S_CLOSE: begin
        cmd.close = 1'b1;
        if (stat.close_ok) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      base_r  <= '0;
      tick_r  <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      tick_r  <= tick_nxt;
      clr_r   <= clr_nxt;
    end
    idx_r     <= idx_nxt;
    end_r     <= end_nxt;
    ack_idx_r <= ack_idx_nxt;
  end

endmodule

`default_nettype wire

### rtl/selective_repeat_sender.sv
// Tick item: scan the window from the base, then close; the scan takes one frame slot per cycle
//   unless the output stalls it, set by the single read port of the frame store.
// Ack item: mark the frame, slide the base past acked frames, then close; an out-of-range ack skips the marking.
// Results leave through an output register; a new item is taken while one waits there.
// Reset (rst_n low, synchronous) clears base and tick count, then a clearing pass zeroes all
//   MAX_FRAME_SLOTS entries of the frame store; no item is taken until it ends.
`default_nettype none

module selective_repeat_sender
  import srs_pkg::*;
#(
  parameter int MAX_FRAME_SLOTS = 128,
  parameter int MAX_WINDOW      = 16,
  parameter int STAMP_BITS      = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_FRAME_SLOTS);
  localparam int DW    = STAMP_BITS + 2;

  cfg_t             cfg_r, cfg_nxt;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [DW-1:0]    mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [DW-1:0]    mem_rdata;
  obuf_cmd_t        cmd;
  obuf_stat_t       stat;

  // Decode register writes; unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT:   cfg_nxt.frame_count   = cfg_wdata[FRAME_COUNT_W-1:0];
        REG_WIN_LEN:       cfg_nxt.win_len       = cfg_wdata[WIN_LEN_W-1:0];
        REG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_wdata[TIMEOUT_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{frame_count: FRAME_COUNT_RST, win_len: WIN_LEN_RST,
                 timeout_ticks: TIMEOUT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srs_seq #(
    .MAX_FRAME_SLOTS (MAX_FRAME_SLOTS),
    .MAX_WINDOW      (MAX_WINDOW),
    .STAMP_BITS      (STAMP_BITS),
    .IDX_W           (IDX_W),
    .DW              (DW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  srs_mem #(
    .DEPTH (MAX_FRAME_SLOTS),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  srs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/srs_chk.sv
`default_nettype none

`include "selective_repeat_sender_defines.svh"

module srs_chk
  import srs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled result holds
  `SRS_ASSERT_ON(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

  // Status results carry no frame and close their item
  `SRS_ASSERT_ON(a_status_form,
    out_valid && out_data.kind == KIND_STATUS |-> out_data.frame_seq == '0 && out_data.last,
    "malformed status result")

  // A sent frame is numbered from one
  `SRS_ASSERT_ON(a_send_seq,
    out_valid && out_data.kind != KIND_STATUS |-> out_data.frame_seq != '0,
    "send with frame number zero")

  // Reset empties the output and blocks input during the clearing pass
  `SRS_ASSERT_ALWAYS(a_reset_state, !rst_n |=> in_stall && !out_valid, "bad state after reset")

endmodule

bind selective_repeat_sender srs_chk u_chk (.*);

`default_nettype wire
